// ===== sv/wvsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wvsd_pkg: shared constants, types and tables for the wind vector block
// Widths of the CORDIC datapath, the square-root datapath and the
// direction arithmetic, the arctangent table and the cell payload.
// ----------------------------------------------------------------------------
package wvsd_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int NUM_CELLS     = (CORDIC_STAGES > DATA_WIDTH) ? CORDIC_STAGES : DATA_WIDTH;
  localparam int IDX_W         = $clog2(NUM_CELLS);
  localparam int GUARD         = 16;
  localparam int CW            = DATA_WIDTH + GUARD + 3;
  localparam int ZW            = 32;
  localparam int SW            = 2 * DATA_WIDTH;
  localparam int SPW           = (DATA_WIDTH + 1 > 16) ? DATA_WIDTH + 1 : 16;
  localparam int DDW           = ZW - GUARD + 1;
  localparam int THR_W         = 16;
  localparam int SPEED_W       = 16;
  localparam int DIR_W         = 15;

  typedef logic        [IDX_W-1:0] idx_t;
  typedef logic        [4:0]       atan_idx_t;
  typedef logic signed [CW-1:0]    coord_t;
  typedef logic signed [ZW-1:0]    angle_t;
  typedef logic        [SW-1:0]    sq_t;
  typedef logic signed [DDW-1:0]   dir_t;

  localparam angle_t ANG_90   = 377487360;
  localparam angle_t ROUND_Z  = 32768;
  localparam dir_t   DIR_HALF = 11520;
  localparam dir_t   DIR_FULL = 23040;
  localparam sq_t    SQ_TOP   = {2'b01, {(SW-2){1'b0}}};

  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    angle_t z;
    sq_t    rem;
    sq_t    root;
  } cell_t;

  // atan(2^-i) in units of 1/(64*65536) degree
  function automatic angle_t atan_entry(input atan_idx_t i);
    angle_t a;
    unique case (i)
      5'd0:  a = 188743680;
      5'd1:  a = 111421900;
      5'd2:  a = 58872272;
      5'd3:  a = 29884485;
      5'd4:  a = 15000234;
      5'd5:  a = 7507429;
      5'd6:  a = 3754631;
      5'd7:  a = 1877430;
      5'd8:  a = 938729;
      5'd9:  a = 469366;
      5'd10: a = 234683;
      5'd11: a = 117342;
      5'd12: a = 58671;
      5'd13: a = 29335;
      5'd14: a = 14668;
      5'd15: a = 7334;
      5'd16: a = 3667;
      5'd17: a = 1833;
      5'd18: a = 917;
      5'd19: a = 458;
      5'd20: a = 229;
      5'd21: a = 115;
      5'd22: a = 57;
      5'd23: a = 29;
      5'd24: a = 14;
      5'd25: a = 7;
      5'd26: a = 4;
      5'd27: a = 2;
      5'd28: a = 1;
      5'd29: a = 0;
      5'd30: a = 0;
      5'd31: a = 0;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/wvsd_front.sv =====
// ----------------------------------------------------------------------------
// wvsd_front: squares, sum of squares and half-plane pre-rotation
// Two register stages that load the first cell of the chain.
// ----------------------------------------------------------------------------
module wvsd_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  logic                                   in_valid,
  input  logic signed [wvsd_pkg::DATA_WIDTH-1:0] east,
  input  logic signed [wvsd_pkg::DATA_WIDTH-1:0] north,
  output wvsd_pkg::cell_t                        cell_out
);

  logic signed [wvsd_pkg::SW-1:0] usq_full;
  logic signed [wvsd_pkg::SW-1:0] vsq_full;
  wvsd_pkg::coord_t               ue;
  wvsd_pkg::coord_t               ve;
  wvsd_pkg::coord_t               x_nxt;
  wvsd_pkg::coord_t               y_nxt;
  wvsd_pkg::angle_t               z_nxt;

  logic                           a_valid_r;
  wvsd_pkg::sq_t                  usq_r;
  wvsd_pkg::sq_t                  vsq_r;
  wvsd_pkg::coord_t               x_r;
  wvsd_pkg::coord_t               y_r;
  wvsd_pkg::angle_t               z_r;

  wvsd_pkg::cell_t                b_nxt;
  wvsd_pkg::cell_t                b_r;

  assign usq_full = east * east;
  assign vsq_full = north * north;

  always_comb begin
    ue = {{(wvsd_pkg::CW-wvsd_pkg::DATA_WIDTH-wvsd_pkg::GUARD){east[wvsd_pkg::DATA_WIDTH-1]}},
          east, {wvsd_pkg::GUARD{1'b0}}};
    ve = {{(wvsd_pkg::CW-wvsd_pkg::DATA_WIDTH-wvsd_pkg::GUARD){north[wvsd_pkg::DATA_WIDTH-1]}},
          north, {wvsd_pkg::GUARD{1'b0}}};
    // turn left half plane into right half plane
    if (ve < 0) begin
      if (ue >= 0) begin
        x_nxt = ue;
        y_nxt = -ve;
        z_nxt = wvsd_pkg::ANG_90;
      end else begin
        x_nxt = -ue;
        y_nxt = ve;
        z_nxt = -wvsd_pkg::ANG_90;
      end
    end else begin
      x_nxt = ve;
      y_nxt = ue;
      z_nxt = '0;
    end
  end

  always_comb begin
    b_nxt.valid = a_valid_r;
    b_nxt.x     = x_r;
    b_nxt.y     = y_r;
    b_nxt.z     = z_r;
    b_nxt.rem   = usq_r + vsq_r;
    b_nxt.root  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_r.valid <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
      b_r.valid <= b_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      usq_r     <= usq_full;
      vsq_r     <= vsq_full;
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      z_r       <= z_nxt;
      b_r.x     <= b_nxt.x;
      b_r.y     <= b_nxt.y;
      b_r.z     <= b_nxt.z;
      b_r.rem   <= b_nxt.rem;
      b_r.root  <= b_nxt.root;
    end
  end

  assign cell_out = b_r;

endmodule

// ===== sv/wvsd_cell.sv =====
// ----------------------------------------------------------------------------
// wvsd_cell: one cell of the chain
// One CORDIC vectoring micro-rotation (while idx < CORDIC_STAGES) and one
// square-root digit (idx < DATA_WIDTH), registered and handed to the next cell.
// ----------------------------------------------------------------------------
module wvsd_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  wvsd_pkg::idx_t   idx,
  input  wvsd_pkg::cell_t  cell_in,
  output wvsd_pkg::cell_t  cell_out
);

  logic                         cordic_en;
  logic                         sqrt_en;
  wvsd_pkg::coord_t             dx;
  wvsd_pkg::coord_t             dy;
  wvsd_pkg::angle_t             atan_val;
  wvsd_pkg::sq_t                sbit;
  logic [wvsd_pkg::SW:0]        trial;
  wvsd_pkg::cell_t              cell_nxt;
  wvsd_pkg::cell_t              cell_r;

  always_comb begin
    cordic_en = (idx < wvsd_pkg::CORDIC_STAGES);
    sqrt_en   = (idx < wvsd_pkg::DATA_WIDTH);
    dx        = cell_in.y >>> idx;
    dy        = cell_in.x >>> idx;
    atan_val  = wvsd_pkg::atan_entry(wvsd_pkg::atan_idx_t'(idx));
    sbit      = wvsd_pkg::SQ_TOP >> {idx, 1'b0};
    trial     = {1'b0, cell_in.root} + {1'b0, sbit};
    cell_nxt  = cell_in;
    if (cordic_en) begin
      if (cell_in.y > 0) begin
        cell_nxt.x = cell_in.x + dx;
        cell_nxt.y = cell_in.y - dy;
        cell_nxt.z = cell_in.z + atan_val;
      end else begin
        cell_nxt.x = cell_in.x - dx;
        cell_nxt.y = cell_in.y + dy;
        cell_nxt.z = cell_in.z - atan_val;
      end
    end
    if (sqrt_en) begin
      if ({1'b0, cell_in.rem} >= trial) begin
        cell_nxt.rem  = cell_in.rem - trial[wvsd_pkg::SW-1:0];
        cell_nxt.root = (cell_in.root >> 1) + sbit;
      end else begin
        cell_nxt.root = cell_in.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (adv) begin
      cell_r.valid <= cell_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_r.x    <= cell_nxt.x;
      cell_r.y    <= cell_nxt.y;
      cell_r.z    <= cell_nxt.z;
      cell_r.rem  <= cell_nxt.rem;
      cell_r.root <= cell_nxt.root;
    end
  end

  assign cell_out = cell_r;

endmodule

// ===== sv/wvsd_back.sv =====
// ----------------------------------------------------------------------------
// wvsd_back: rounding, direction wrap and calm detection
// Two register stages; the second one is the output register.
// ----------------------------------------------------------------------------
module wvsd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  wvsd_pkg::cell_t                cell_in,
  input  logic [wvsd_pkg::THR_W-1:0]     calm_threshold,
  output logic                           out_valid,
  output logic [wvsd_pkg::SPEED_W-1:0]   out_speed,
  output logic [wvsd_pkg::DIR_W-1:0]     out_direction,
  output logic                           out_calm
);

  logic                              rnd;
  logic                              zero_vec;
  wvsd_pkg::angle_t                  zsum;
  wvsd_pkg::angle_t                  zsh;
  logic [wvsd_pkg::SPW-1:0]          spd_nxt;
  wvsd_pkg::dir_t                    dir_nxt;

  logic                              s1_valid_r;
  logic [wvsd_pkg::SPW-1:0]          spd_r;
  wvsd_pkg::dir_t                    dir_r;

  logic                              calm_nxt;
  wvsd_pkg::dir_t                    wrap;
  logic [wvsd_pkg::DIR_W-1:0]        direction_nxt;

  logic                              out_valid_r;
  logic [wvsd_pkg::SPEED_W-1:0]      speed_r;
  logic [wvsd_pkg::DIR_W-1:0]        direction_r;
  logic                              calm_r;

  always_comb begin
    rnd      = (cell_in.rem > cell_in.root);
    spd_nxt  = cell_in.root[wvsd_pkg::SPW-1:0] + {{(wvsd_pkg::SPW-1){1'b0}}, rnd};
    zero_vec = (cell_in.root == '0) && (cell_in.rem == '0);
    zsum     = cell_in.z + wvsd_pkg::ROUND_Z;
    zsh      = zsum >>> wvsd_pkg::GUARD;
    if (zero_vec) begin
      dir_nxt = wvsd_pkg::DIR_HALF;
    end else begin
      dir_nxt = wvsd_pkg::dir_t'(zsh[wvsd_pkg::DDW-1:0]) + wvsd_pkg::DIR_HALF;
    end
  end

  always_comb begin
    calm_nxt = (spd_r < calm_threshold);
    priority if (dir_r < 0) begin
      wrap = dir_r + wvsd_pkg::DIR_FULL;
    end else if (dir_r >= wvsd_pkg::DIR_FULL) begin
      wrap = dir_r - wvsd_pkg::DIR_FULL;
    end else begin
      wrap = dir_r;
    end
    if (calm_nxt || wrap < 0 || wrap >= wvsd_pkg::DIR_FULL) begin
      direction_nxt = '0;
    end else begin
      direction_nxt = wrap[wvsd_pkg::DIR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= cell_in.valid;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      spd_r       <= spd_nxt;
      dir_r       <= dir_nxt;
      speed_r     <= spd_r[wvsd_pkg::SPEED_W-1:0];
      direction_r <= direction_nxt;
      calm_r      <= calm_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_speed     = speed_r;
  assign out_direction = direction_r;
  assign out_calm      = calm_r;

endmodule

// ===== sv/wind_vector_to_speed_direction.sv =====
// ----------------------------------------------------------------------------
// wind_vector_to_speed_direction: wind speed and direction from u/v components
// Rounded magnitude and CORDIC direction of one wind vector per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one transaction carries a signed Q8.8 east and north
//   component. Output channel out_*: speed (Q8.8, rounded), direction in
//   1/64 degree with 180 degrees added (0..23039), and the calm flag.
//   Config channel cfg_*: writes the calm threshold; cfg_ready is always high.
//   A speed below the threshold reports calm with direction zero.
// Timing:
//   Pipeline: two front stages, one cell per CORDIC micro-rotation / root
//   digit, two back stages; every stage is one register.
//   Throughput is one transaction per cycle unless a result waits with out_ready low.
// Reset:
//   Clears all valid bits and sets the calm threshold to 1.
// Stall:
//   While a result waits with out_ready low, the whole pipeline holds and
//   in_ready drops; bubbles keep flowing as long as the output is free.
// ----------------------------------------------------------------------------
module wind_vector_to_speed_direction (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [wvsd_pkg::DATA_WIDTH-1:0] in_east_component,
  input  logic signed [wvsd_pkg::DATA_WIDTH-1:0] in_north_component,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [wvsd_pkg::SPEED_W-1:0]           out_speed,
  output logic [wvsd_pkg::DIR_W-1:0]             out_direction,
  output logic                                   out_calm,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [wvsd_pkg::THR_W-1:0]             cfg_calm_threshold
);

  logic                          adv;
  logic [wvsd_pkg::THR_W-1:0]    calm_thr_r;
  wvsd_pkg::cell_t               chain [0:wvsd_pkg::NUM_CELLS];

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calm_thr_r <= {{(wvsd_pkg::THR_W-1){1'b0}}, 1'b1};
    end else if (cfg_valid && cfg_ready) begin
      calm_thr_r <= cfg_calm_threshold;
    end
  end

  wvsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .east     (in_east_component),
    .north    (in_north_component),
    .cell_out (chain[0])
  );

  for (genvar g = 0; g < wvsd_pkg::NUM_CELLS; g++) begin : g_cell
    wvsd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .idx      (wvsd_pkg::idx_t'(g)),
      .cell_in  (chain[g]),
      .cell_out (chain[g+1])
    );
  end

  wvsd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .cell_in        (chain[wvsd_pkg::NUM_CELLS]),
    .calm_threshold (calm_thr_r),
    .out_valid      (out_valid),
    .out_speed      (out_speed),
    .out_direction  (out_direction),
    .out_calm       (out_calm)
  );

endmodule

// ===== sv/wvsd_checker.sv =====
// ----------------------------------------------------------------------------
// wvsd_checker: port-level checks for the wind vector block
// Output hold under stall, calm and zero-vector encodings, direction range.
// ----------------------------------------------------------------------------
module wvsd_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic [wvsd_pkg::SPEED_W-1:0]           out_speed,
  input logic [wvsd_pkg::DIR_W-1:0]             out_direction,
  input logic                                   out_calm
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_speed) &&
    $stable(out_direction) && $stable(out_calm))
    else $error("result changed while stalled");

  a_calm_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_calm |-> out_direction == '0)
    else $error("calm result with nonzero direction");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_direction < 15'd23040)
    else $error("direction out of range");

  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_calm && out_speed == '0 |-> out_direction == 15'd11520)
    else $error("zero vector direction wrong");

endmodule

bind wind_vector_to_speed_direction wvsd_checker u_wvsd_checker (.*);

// ===== verif/tb_wind_vector_to_speed_direction.sv =====
// ----------------------------------------------------------------------------
// tb_wind_vector_to_speed_direction: self-checking bench for the wind block
// Drives signed u/v vectors through the valid/ready input channel, predicts
// the rounded speed, CORDIC direction and calm flag of every transaction,
// and compares each result in order. Directed corners come first, then
// random vectors under several calm thresholds, with random idling on both
// sides, one stretch with no idling and a drain pause partway through.
// ----------------------------------------------------------------------------

typedef logic signed [wvsd_pkg::DATA_WIDTH-1:0] comp_t;

class wind_scoreboard;

  typedef struct {
    logic [wvsd_pkg::SPEED_W-1:0] speed;
    logic [wvsd_pkg::DIR_W-1:0]   direction;
    logic                         calm;
  } reading_t;

  localparam longint QUARTER_TURN = 377487360;
  localparam longint HALF_STEP    = 32768;
  localparam longint DIR_OFFSET   = 11520;
  localparam longint DIR_WRAP     = 23040;

  reading_t         pending_readings[$];
  logic [15:0]      threshold;
  int unsigned      mismatches;
  int unsigned      checked;
  int unsigned      calm_seen;

  function new();
    threshold  = 16'd1;
    mismatches = 0;
    checked    = 0;
    calm_seen  = 0;
  endfunction

  function void set_threshold(logic [15:0] value);
    threshold = value;
  endfunction

  function int outstanding();
    return pending_readings.size();
  endfunction

  // predict speed, direction and calm flag of one wind vector
  function void note_vector(comp_t east, comp_t north);
    longint          e, n, x, y, z, t, dx, dy, d;
    longint unsigned rem, root, b;
    reading_t        r;
    longint          step_angle [32] = '{
      188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
      3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2,
      1, 0, 0, 0};
    e = east;
    n = north;
    rem  = e * e + n * n;
    root = 0;
    b    = 64'h4000_0000_0000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    if (rem > root) root = root + 1;
    r.speed     = root[15:0];
    r.direction = '0;
    r.calm      = 1'b0;
    if (root < threshold) begin
      r.calm = 1'b1;
    end else begin
      x = n * 65536;
      y = e * 65536;
      z = 0;
      if (e != 0 || n != 0) begin
        // fold the left half plane into the right one
        if (x < 0) begin
          t = x;
          if (y >= 0) begin
            x = y;
            y = -t;
            z = QUARTER_TURN;
          end else begin
            x = -y;
            y = t;
            z = -QUARTER_TURN;
          end
        end
        for (int i = 0; i < wvsd_pkg::CORDIC_STAGES && i < 32; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y > 0) begin
            x = x + dx;
            y = y - dy;
            z = z + step_angle[i];
          end else begin
            x = x - dx;
            y = y + dy;
            z = z - step_angle[i];
          end
        end
      end
      d = ((z + HALF_STEP) >>> 16) + DIR_OFFSET;
      if (d < 0) d = d + DIR_WRAP;
      if (d >= DIR_WRAP) d = d - DIR_WRAP;
      if (d < 0 || d >= DIR_WRAP) d = 0;
      r.direction = d[14:0];
    end
    pending_readings.push_back(r);
  endfunction

  function void check_reading(logic [wvsd_pkg::SPEED_W-1:0] speed,
                              logic [wvsd_pkg::DIR_W-1:0] direction, logic calm);
    reading_t want;
    if (pending_readings.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected reading speed=%0d direction=%0d calm=%0d",
                 speed, direction, calm);
      return;
    end
    want = pending_readings.pop_front();
    checked++;
    if (want.calm) calm_seen++;
    if (speed !== want.speed || direction !== want.direction || calm !== want.calm) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: reading %0d expected speed=%0d direction=%0d calm=%0d",
                 checked, want.speed, want.direction, want.calm);
        $display("       got speed=%0d direction=%0d calm=%0d",
                 speed, direction, calm);
      end
    end
  endfunction

endclass

module tb_wind_vector_to_speed_direction;

  localparam int STALL_LIMIT = 4000;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  comp_t                        in_east_component;
  comp_t                        in_north_component;
  logic                         out_valid;
  logic                         out_ready;
  logic [wvsd_pkg::SPEED_W-1:0] out_speed;
  logic [wvsd_pkg::DIR_W-1:0]   out_direction;
  logic                         out_calm;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [wvsd_pkg::THR_W-1:0]   cfg_calm_threshold;

  wind_scoreboard sb;
  int unsigned    in_idle_pct;
  int unsigned    out_idle_pct;
  int unsigned    vectors_sent;
  int unsigned    settings_used;
  int unsigned    stall_cycles = 0;

  wind_vector_to_speed_direction i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_east_component  (in_east_component),
    .in_north_component (in_north_component),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_speed          (out_speed),
    .out_direction      (out_direction),
    .out_calm           (out_calm),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_calm_threshold (cfg_calm_threshold)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // leave in_valid high on return; callers drop it before any pause
  task automatic send_vector(input comp_t east, input comp_t north);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid           = 1'b1;
    in_east_component  = east;
    in_north_component = north;
    do @(posedge clk); while (!in_ready);
    sb.note_vector(east, north);
    vectors_sent++;
    @(negedge clk);
  endtask

  task automatic drain_readings();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [wvsd_pkg::THR_W-1:0] value);
    cfg_valid          = 1'b1;
    cfg_calm_threshold = value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_threshold(value);
    settings_used++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(input int count);
    int unsigned mode;
    comp_t       east, north;
    comp_t       extremes [6] = '{-32768, -32767, -1, 0, 1, 32767};
    for (int k = 0; k < count; k++) begin
      mode = $urandom_range(99);
      if (mode < 50) begin
        east  = comp_t'($urandom);
        north = comp_t'($urandom);
      end else if (mode < 70) begin
        east  = comp_t'(int'($urandom_range(4095)) - 2048);
        north = comp_t'(int'($urandom_range(4095)) - 2048);
      end else if (mode < 80) begin
        east  = comp_t'(int'($urandom_range(16)) - 8);
        north = comp_t'(int'($urandom_range(16)) - 8);
      end else if (mode < 90) begin
        east  = comp_t'($urandom);
        north = comp_t'($urandom);
        if ($urandom_range(1)) east = '0;
        else north = '0;
      end else begin
        east  = extremes[$urandom_range(5)];
        north = extremes[$urandom_range(5)];
      end
      send_vector(east, north);
    end
  endtask

  task automatic run_directed();
    comp_t east_pts [25] = '{0, 1, 0, -1, 0, 32767, -32768, 0, 0, -32768, 32767,
                             -32768, 32767, 256, -256, -256, 256, 1, -1, 3, 0,
                             -1, 1, -7, 181};
    comp_t north_pts [25] = '{0, 0, 1, 0, -1, 0, 0, 32767, -32768, -32768, 32767,
                              32767, -32768, 256, 256, -256, -256, 1, -1, -4, -5,
                              -32768, -32768, 0, -181};
    for (int k = 0; k < 25; k++) send_vector(east_pts[k], north_pts[k]);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_reading(out_speed, out_direction, out_calm);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAIL wind_vector_to_speed_direction");
        $finish;
      end
    end
  end

  initial begin
    sb                 = new();
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_east_component  = '0;
    in_north_component = '0;
    cfg_valid          = 1'b0;
    cfg_calm_threshold = '0;
    in_idle_pct        = 38;
    out_idle_pct       = 38;
    vectors_sent       = 0;
    settings_used      = 1;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed();

    drain_readings();
    write_threshold(16'd0);
    send_vector(0, 0);
    send_vector(0, -3);
    run_random(250);

    drain_readings();
    write_threshold(16'hFFFF);
    run_random(100);

    drain_readings();
    write_threshold(16'($urandom_range(4096)));
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(300);
    in_idle_pct  = 38;
    out_idle_pct = 38;

    drain_readings();
    write_threshold(16'd46341);
    send_vector(-32768, -32768);
    send_vector(-32768, 32767);
    send_vector(32767, -32768);
    send_vector(32767, 32767);
    run_random(100);

    drain_readings();
    write_threshold(16'd256);
    run_random(150);
    // hold the sender until the pipeline is empty
    drain_readings();
    run_random(150);

    drain_readings();
    write_threshold(16'd1);
    run_random(475);

    drain_readings();
    repeat (30) @(negedge clk);

    $display("Covered %0d wind vectors under %0d calm thresholds, %0d calm results.",
             vectors_sent, settings_used, sb.calm_seen);
    $display("Checked %0d results, %0d mismatches, %0d still outstanding.",
             sb.checked, sb.mismatches, sb.outstanding());
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS wind_vector_to_speed_direction");
    end else begin
      $display("FAIL wind_vector_to_speed_direction");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/wvsd_pkg.sv
sv/wvsd_front.sv
sv/wvsd_cell.sv
sv/wvsd_back.sv
sv/wind_vector_to_speed_direction.sv
sv/wvsd_checker.sv
verif/tb_wind_vector_to_speed_direction.sv
